>>> src/rng64xra_pkg.sv
// Package: shared types, constants and update functions for the 64-bit rotate/add generator.
package rng64xra_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned ShiftOld   = 13;
  localparam int unsigned RotThree   = 3;
  localparam int unsigned RotOne     = 5;
  localparam int unsigned RotOut     = 21;
  localparam int unsigned WarmupSteps = 8;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    OP_NEXT     = 2'd0,
    OP_SEED_ONE = 2'd1,
    OP_SEED_TWO = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef struct packed {
    word_t one;
    word_t two;
    word_t three;
  } words_t;

  // one accepted request as held in the input register
  typedef struct packed {
    op_t   op;
    word_t seed_first;
    word_t seed_second;
  } req_t;

  // partial result handed to the output stage
  typedef struct packed {
    word_t sum_rot;
    word_t one_next;
  } pre_t;

  localparam word_t WordOne = word_t'(1);

  function automatic word_t rotl_three(input word_t x);
    rotl_three = {x[WordW-1-RotThree:0], x[WordW-1:WordW-RotThree]};
  endfunction

  function automatic word_t rotl_one(input word_t x);
    rotl_one = {x[WordW-1-RotOne:0], x[WordW-1:WordW-RotOne]};
  endfunction

  function automatic word_t rotl_out(input word_t x);
    rotl_out = {x[WordW-1-RotOut:0], x[WordW-1:WordW-RotOut]};
  endfunction

  // one state update: xor, shift and rotate only
  function automatic words_t step(input words_t s);
    words_t n;
    word_t  t;
    t       = s.one >> ShiftOld;
    n.three = s.three ^ s.one;
    n.one   = s.one ^ s.two;
    n.two   = s.two ^ n.three;
    n.one   = n.one ^ t;
    n.three = rotl_three(n.three);
    n.one   = rotl_one(n.one);
    step    = n;
  endfunction

  function automatic words_t warm_up(input words_t s);
    words_t w;
    w = s;
    for (int i = 0; i < WarmupSteps; i++) begin
      w = step(w);
    end
    warm_up = w;
  endfunction

endpackage

>>> src/rng64xra_state.sv
// State words with the single-pass update, seed load and unrolled warm-up network.
module rng64xra_state
  import rng64xra_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  output pre_t pre
);

  words_t words_r;
  words_t words_nxt;
  words_t stepped;
  words_t seeded;

  always_comb begin
    stepped      = step(words_r);
    seeded.one   = req.seed_first;
    seeded.two   = (req.op == OP_SEED_TWO) ? req.seed_second : WordOne;
    seeded.three = WordOne;
    pre.sum_rot  = rotl_out(words_r.one + words_r.three);
    pre.one_next = stepped.one;
  end

  always_comb begin
    words_nxt = words_r;
    if (fire) begin
      unique case (req.op)
        OP_NEXT:     words_nxt = stepped;
        OP_SEED_ONE,
        OP_SEED_TWO: words_nxt = warm_up(seeded);
        OP_NONE:     words_nxt = words_r;
        default:     words_nxt = words_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '{one: WordOne, two: WordOne, three: WordOne};
    end else begin
      words_r <= words_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!fire || req.op == OP_NONE) |=> $stable(words_r))
    else $error("state changed without a request");

  a_seed_third: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (req.op == OP_SEED_ONE || req.op == OP_SEED_TWO))
      |=> words_r == warm_up($past(seeded)))
    else $error("seed load mismatch");

  a_next_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req.op == OP_NEXT) |=> words_r.one == $past(pre.one_next))
    else $error("word one not advanced");
`endif

endmodule

>>> src/rng64xra_out_stage.sv
// Final add stage and output register with valid/ready handshake.
module rng64xra_out_stage
  import rng64xra_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  pre_t  pre,
  output logic  free,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_random_value
);

  logic  s1_v_r;
  pre_t  s1_r;
  logic  out_v_r;
  word_t out_val_r;
  logic  s1_adv;

  assign s1_adv = s1_v_r && (!out_v_r || out_ready);
  assign free   = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= load || (s1_v_r && !s1_adv);
      out_v_r <= s1_adv || (out_v_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= pre;
    end
    if (s1_adv) begin
      out_val_r <= s1_r.sum_rot + s1_r.one_next;
    end
  end

  assign out_valid        = out_v_r;
  assign out_random_value = out_val_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("load into a busy stage");

  a_adv_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r && out_val_r == $past(s1_r.sum_rot + s1_r.one_next))
    else $error("result not registered");

  a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> s1_v_r)
    else $error("pending request dropped");
`endif

endmodule

>>> src/rng64_xor_rotate_add_core.sv
// Top level: input register and handshake of the 64-bit xor/rotate/add generator.
//
//  channel | ports                                       | handshake
//  --------+---------------------------------------------+--------------------
//  request | in_opcode, in_seed_first, in_seed_second    | in_valid / in_ready
//  result  | out_random_value                            | out_valid / out_ready
//
// One request per cycle sustained while results are taken; a next request goes from the input
// register into the add stage with the state update, then into the final add register.
// Seed requests apply the eight warm-up updates combinationally in one state update.
// Synchronous active-low reset sets all three state words to one.
// A stalled result holds the output; the input keeps flowing until both stages
// and the input register fill.
module rng64_xor_rotate_add_core
  import rng64xra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_seed_first,
  input  logic [63:0] in_seed_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_random_value
);

  logic s0_v_r;
  req_t s0_r;
  logic s0_adv;
  logic s1_free;
  pre_t pre;

  assign s0_adv   = s0_v_r && (s0_r.op != OP_NEXT || s1_free);
  assign in_ready = !s0_v_r || s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= (in_valid && in_ready) || (s0_v_r && !s0_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_r.op          <= op_t'(in_opcode);
      s0_r.seed_first  <= in_seed_first;
      s0_r.seed_second <= in_seed_second;
    end
  end

  rng64xra_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s0_adv),
    .req   (s0_r),
    .pre   (pre)
  );

  rng64xra_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s0_adv && s0_r.op == OP_NEXT),
    .pre              (pre),
    .free             (s1_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

`ifndef SYNTHESIS
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_v_r && !s0_adv) |=> s0_v_r && $stable(s0_r))
    else $error("held request lost");

  a_seed_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_v_r && s0_r.op != OP_NEXT) |-> s0_adv)
    else $error("seed request stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s0_v_r && !out_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> verif/rng64_xor_rotate_add_checker.sv
`timescale 1ns / 100ps
// Checker: tracks generator state from accepted requests and compares each result.
module rng64_xor_rotate_add_checker
  import rng64xra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_seed_first,
  input  logic [63:0] in_seed_second,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_random_value,
  output int          fail_count,
  output int          pending
);

  word_t st_one;
  word_t st_two;
  word_t st_three;
  word_t expected_values[$];
  word_t exp_value;
  int    fails = 0;
  int    pend_count = 0;

  assign fail_count = fails;
  assign pending    = pend_count;

  function automatic word_t rotl64(input word_t x, input int unsigned r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  // one state update, returns the generated value
  function automatic word_t advance_words();
    word_t sum_rot;
    word_t t;
    sum_rot  = rotl64(st_one + st_three, RotOut);
    t        = st_one >> ShiftOld;
    st_three = st_three ^ st_one;
    st_one   = st_one ^ st_two;
    st_two   = st_two ^ st_three;
    st_one   = st_one ^ t;
    st_three = rotl64(st_three, RotThree);
    st_one   = rotl64(st_one, RotOne);
    return sum_rot + st_one;
  endfunction

  function automatic void warm_up_words();
    for (int i = 0; i < WarmupSteps; i++) begin
      void'(advance_words());
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      st_one   = WordOne;
      st_two   = WordOne;
      st_three = WordOne;
      expected_values.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          $error("random_value: no result expected, got %h", out_random_value);
          fails++;
        end else begin
          exp_value = expected_values.pop_front();
          if (out_random_value !== exp_value) begin
            $error("random_value: expected %h, got %h", exp_value, out_random_value);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (op_t'(in_opcode))
          OP_NEXT: begin
            expected_values.push_back(advance_words());
          end
          OP_SEED_ONE: begin
            st_one   = in_seed_first;
            st_two   = WordOne;
            st_three = WordOne;
            warm_up_words();
          end
          OP_SEED_TWO: begin
            st_one   = in_seed_first;
            st_two   = in_seed_second;
            st_three = WordOne;
            warm_up_words();
          end
          default: begin
          end
        endcase
      end
    end
    pend_count = expected_values.size();
  end

endmodule

>>> verif/tb_rng64_xor_rotate_add_core.sv
`timescale 1ns / 100ps
// Testbench top: drives requests and result backpressure, then reports the verdict.
module tb_rng64_xor_rotate_add_core;
  import rng64xra_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_NONE;
  logic [63:0] in_seed_first = '0;
  logic [63:0] in_seed_second = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_random_value;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_done = 0;
  int fail_count;
  int pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rng64_xor_rotate_add_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_seed_first    (in_seed_first),
    .in_seed_second   (in_seed_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

  rng64_xor_rotate_add_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_seed_first    (in_seed_first),
    .in_seed_second   (in_seed_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  // offer one request from the falling edge until accepted
  task automatic send_req(input op_t op, input word_t s1, input word_t s2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_seed_first  = s1;
    in_seed_second = s2;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random_req();
    int   r;
    op_t  op;
    r = $urandom_range(99);
    if (r < 64) begin
      op = OP_NEXT;
    end else if (r < 76) begin
      op = OP_SEED_ONE;
    end else if (r < 88) begin
      op = OP_SEED_TWO;
    end else begin
      op = OP_NONE;
    end
    send_req(op, rand64(), rand64());
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_seq != hold_done) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_done = hold_seq;
      end
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int wait_cycles;
    wait_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_req(OP_NEXT, '0, '0);
    send_req(OP_NEXT, '1, '1);
    send_req(OP_NEXT, rand64(), rand64());
    send_req(OP_NONE, '1, '1);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_SEED_ONE, '0, '1);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_SEED_ONE, '1, '0);
    send_req(OP_NEXT, '1, '1);
    send_req(OP_SEED_TWO, '0, '0);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_SEED_TWO, '1, '1);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_SEED_TWO, 64'h8000_0000_0000_0000, 64'h1);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_SEED_TWO, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_NEXT, '0, '0);
    send_req(OP_NONE, '0, '0);
    send_req(OP_NEXT, '0, '0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        3: begin
          send_idle_pct  = 31;
          recv_stall_pct = 31;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_seq++;
        end
      endcase
      repeat (210) send_random_req();
    end

    in_valid       = 1'b0;
    recv_stall_pct = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending != 0) $error("%0d results never arrived", pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
